### hw/rtl/scoped_symbol_table_defines.svh
// Assertion macros used by the symbol table RTL.
`ifndef SCOPED_SYMBOL_TABLE_DEFINES_SVH
`define SCOPED_SYMBOL_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SST_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("symbol table check failed");

// Next-cycle implication, disabled while reset is high.
`define SST_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("symbol table check failed");

`endif

### hw/rtl/sst_pkg.sv
package sst_pkg;

   localparam int LINE_BITS = 15;

   localparam logic [1:0] KIND_ENTER   = 2'd0;
   localparam logic [1:0] KIND_EXIT    = 2'd1;
   localparam logic [1:0] KIND_DECLARE = 2'd2;
   localparam logic [1:0] KIND_FIND    = 2'd3;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_REFUSED   = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;
   localparam logic [1:0] STATUS_SCOPE_OVF = 2'd3;

   typedef struct packed {
      logic                 valid;
      logic [1:0]           status;
      logic [LINE_BITS-1:0] found_line;
   } sst_rsp_type;

endpackage

### hw/rtl/sst_entry_ram.sv
module sst_entry_ram
   import sst_pkg::*;
#(
   parameter int ENTRIES    = 64,
   parameter int KEY_BITS   = 64,
   parameter int SCOPE_BITS = 8
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(ENTRIES)-1:0] wr_addr,
   input  logic [KEY_BITS-1:0]        wr_key,
   input  logic [LINE_BITS-1:0]       wr_line,
   input  logic [SCOPE_BITS-1:0]      wr_scope,
   input  logic                       rd_en,
   input  logic [$clog2(ENTRIES)-1:0] rd_addr,
   output logic [KEY_BITS-1:0]        rd_key,
   output logic [LINE_BITS-1:0]       rd_line,
   output logic [SCOPE_BITS-1:0]      rd_scope
);

   localparam int WORD_BITS = KEY_BITS + LINE_BITS + SCOPE_BITS;

   logic [WORD_BITS-1:0] mem [ENTRIES];
   logic [WORD_BITS-1:0] rd_word_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_key, wr_line, wr_scope};
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_word_ff <= mem[rd_addr];
      end
   end

   assign rd_key   = rd_word_ff[WORD_BITS-1 -: KEY_BITS];
   assign rd_line  = rd_word_ff[SCOPE_BITS +: LINE_BITS];
   assign rd_scope = rd_word_ff[SCOPE_BITS-1:0];

endmodule

### hw/rtl/sst_ctrl.sv
module sst_ctrl
   import sst_pkg::*;
#(
   parameter int ENTRIES   = 64,
   parameter int KEY_BITS  = 64,
   parameter int MAX_SCOPE = 255
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [1:0]                         req_kind,
   input  logic [63:0]                        req_key,
   input  logic                               req_key_empty,
   input  logic [15:0]                        req_line,
   output logic                               busy,
   output sst_rsp_type                        rsp,
   output logic                               wr_en,
   output logic [$clog2(ENTRIES)-1:0]         wr_addr,
   output logic [KEY_BITS-1:0]                wr_key,
   output logic [LINE_BITS-1:0]               wr_line,
   output logic [$clog2(MAX_SCOPE+1)-1:0]     wr_scope,
   output logic                               rd_en,
   output logic [$clog2(ENTRIES)-1:0]         rd_addr,
   input  logic [KEY_BITS-1:0]                rd_key,
   input  logic [LINE_BITS-1:0]               rd_line,
   input  logic [$clog2(MAX_SCOPE+1)-1:0]     rd_scope
);

   localparam int AW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);
   localparam int LW = $clog2(MAX_SCOPE + 1);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_SCAN = 1'b1;

   logic                 state_ff, state_in;
   logic [1:0]           kind_ff, kind_in;
   logic [KEY_BITS-1:0]  key_ff, key_in;
   logic [LINE_BITS-1:0] line_ff, line_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [LW-1:0]        level_ff, level_in;
   logic [CW-1:0]        ptr_ff, ptr_in;
   logic                 rd_valid_ff, rd_valid_in;
   logic [AW-1:0]        rd_addr_ff, rd_addr_in;
   logic [CW-1:0]        ptr_dec;
   logic                 key_hit;
   logic                 in_scope;
   logic                 exhausted;

   assign ptr_dec   = ptr_ff - CW'(1);
   assign key_hit   = rd_valid_ff && (rd_key == key_ff);
   assign in_scope  = rd_scope == level_ff;
   assign exhausted = !rd_valid_ff && (ptr_ff == '0);

   assign busy     = state_ff == S_SCAN;
   assign rd_addr  = rd_addr_in;
   assign wr_addr  = count_ff[AW-1:0];
   assign wr_key   = key_ff;
   assign wr_line  = line_ff;
   assign wr_scope = level_ff;

   always_comb begin
      state_in    = state_ff;
      kind_in     = kind_ff;
      key_in      = key_ff;
      line_in     = line_ff;
      count_in    = count_ff;
      level_in    = level_ff;
      ptr_in      = ptr_ff;
      rd_valid_in = 1'b0;
      rd_addr_in  = rd_addr_ff;
      rd_en       = 1'b0;
      wr_en       = 1'b0;
      rsp         = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               kind_in = req_kind;
               key_in  = req_key[KEY_BITS-1:0];
               line_in = req_line[LINE_BITS-1:0];
               ptr_in  = count_ff;
               case (req_kind)
                  KIND_ENTER: begin
                     rsp.valid = 1'b1;
                     if (level_ff >= LW'(MAX_SCOPE)) begin
                        rsp.status = STATUS_SCOPE_OVF;
                     end else begin
                        level_in = level_ff + LW'(1);
                     end
                  end
                  KIND_EXIT: begin
                     if (level_ff == '0) begin
                        rsp.valid  = 1'b1;
                        rsp.status = STATUS_REFUSED;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  KIND_DECLARE: begin
                     if (req_key_empty || req_line[15]) begin
                        rsp.valid  = 1'b1;
                        rsp.status = STATUS_REFUSED;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                     if (req_key_empty) begin
                        rsp.valid  = 1'b1;
                        rsp.status = STATUS_REFUSED;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
               endcase
            end
         end
         S_SCAN: begin
            // walk the stack from the top, one read issued per cycle
            if (ptr_ff != '0) begin
               rd_en       = 1'b1;
               rd_valid_in = 1'b1;
               rd_addr_in  = ptr_dec[AW-1:0];
               ptr_in      = ptr_dec;
            end
            case (kind_ff)
               KIND_EXIT: begin
                  // entries are ordered by scope, so the first outer one ends the pop
                  if (rd_valid_ff && !in_scope) begin
                     rsp.valid = 1'b1;
                     count_in  = CW'(rd_addr_ff) + CW'(1);
                     level_in  = level_ff - LW'(1);
                  end else if (exhausted) begin
                     rsp.valid = 1'b1;
                     count_in  = '0;
                     level_in  = level_ff - LW'(1);
                  end
               end
               KIND_DECLARE: begin
                  if (key_hit && in_scope) begin
                     rsp.valid  = 1'b1;
                     rsp.status = STATUS_REFUSED;
                  end else if ((rd_valid_ff && !in_scope) || exhausted) begin
                     rsp.valid = 1'b1;
                     if (count_ff == CW'(ENTRIES)) begin
                        rsp.status = STATUS_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CW'(1);
                     end
                  end
               end
               default: begin
                  if (key_hit) begin
                     rsp.valid      = 1'b1;
                     rsp.found_line = rd_line;
                  end else if (exhausted) begin
                     rsp.valid  = 1'b1;
                     rsp.status = STATUS_REFUSED;
                  end
               end
            endcase
            if (rsp.valid) begin
               state_in    = S_IDLE;
               rd_valid_in = 1'b0;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         count_ff    <= '0;
         level_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         level_ff    <= level_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      key_ff     <= key_in;
      line_ff    <= line_in;
      ptr_ff     <= ptr_in;
      rd_addr_ff <= rd_addr_in;
   end

endmodule

### hw/rtl/scoped_symbol_table.sv
// Block-scoped symbol table.
// Request channel: start with req_kind (enter, exit, declare, find), req_key,
// req_key_empty and req_line. An item is taken on a rising edge with start high
// and busy low; busy stays high while the item walks the entry stack.
// Response channel: rsp_valid pulses for one cycle with rsp_status and
// rsp_found_line; there is no backpressure, so the result must be taken then.
// Exactly one result per item.
// Enter, and any item refused on its inputs alone, answers in the cycle
// after it is taken. Exit, declare and find read the entry memory from the top
// of the stack down, one entry per cycle through the memory's single read port
// with registered read data, reading at most the live entries and stopping
// once the result is known.
// A new item can be taken in the cycle its predecessor's result is shown.
// Reset clears the entry count and the scope depth; the entry memory itself
// is not cleared, since only live entries are ever read.
module scoped_symbol_table
   import sst_pkg::*;
#(
   parameter int ENTRIES   = 64,
   parameter int KEY_BITS  = 64,
   parameter int MAX_SCOPE = 255
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [1:0]           req_kind,
   input  logic [63:0]          req_key,
   input  logic                 req_key_empty,
   input  logic signed [15:0]   req_line,
   output logic                 rsp_valid,
   output logic [1:0]           rsp_status,
   output logic [LINE_BITS-1:0] rsp_found_line
);

`include "scoped_symbol_table_defines.svh"

   localparam int AW = $clog2(ENTRIES);
   localparam int LW = $clog2(MAX_SCOPE + 1);

   sst_rsp_type          ctrl_rsp;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [KEY_BITS-1:0]  wr_key;
   logic [LINE_BITS-1:0] wr_line;
   logic [LW-1:0]        wr_scope;
   logic                 rd_en;
   logic [AW-1:0]        rd_addr;
   logic [KEY_BITS-1:0]  rd_key;
   logic [LINE_BITS-1:0] rd_line;
   logic [LW-1:0]        rd_scope;

   logic                 rsp_valid_ff;
   logic [1:0]           rsp_status_ff;
   logic [LINE_BITS-1:0] rsp_found_line_ff;

   sst_ctrl #(
      .ENTRIES   (ENTRIES),
      .KEY_BITS  (KEY_BITS),
      .MAX_SCOPE (MAX_SCOPE)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_kind      (req_kind),
      .req_key       (req_key),
      .req_key_empty (req_key_empty),
      .req_line      (req_line),
      .busy          (busy),
      .rsp           (ctrl_rsp),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_key        (wr_key),
      .wr_line       (wr_line),
      .wr_scope      (wr_scope),
      .rd_en         (rd_en),
      .rd_addr       (rd_addr),
      .rd_key        (rd_key),
      .rd_line       (rd_line),
      .rd_scope      (rd_scope)
   );

   sst_entry_ram #(
      .ENTRIES    (ENTRIES),
      .KEY_BITS   (KEY_BITS),
      .SCOPE_BITS (LW)
   ) u_ram (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_key   (wr_key),
      .wr_line  (wr_line),
      .wr_scope (wr_scope),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_key   (rd_key),
      .rd_line  (rd_line),
      .rd_scope (rd_scope)
   );

   // hold the result in a register for its one-cycle strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctrl_rsp.valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff     <= ctrl_rsp.status;
      rsp_found_line_ff <= ctrl_rsp.found_line;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_found_line = rsp_found_line_ff;

   `SST_ASSERT_NEXT(a_accept_progress, start && !busy, busy || rsp_valid)
   `SST_ASSERT_NOW(a_line_only_on_hit, rsp_valid && rsp_status != STATUS_OK, rsp_found_line == '0)
   `SST_ASSERT_NOW(a_rsp_has_item, rsp_valid, $past(start) || $past(busy))

endmodule
